// File: rtl/tsd_pkg.sv
package tsd_pkg;

    localparam int OFF_W  = 9;
    localparam int SIZE_W = 36;

    localparam logic [OFF_W-1:0] BLK_LAST  = 9'd511;
    localparam logic [OFF_W-1:0] SIZE_OFF  = 9'd124;
    localparam logic [OFF_W-1:0] SIZE_END  = 9'd135;
    localparam logic [OFF_W-1:0] TYPE_OFF  = 9'd156;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SEVEN = 8'h37;

    // parser phase
    localparam logic [2:0] PH_HEAD = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_PAD  = 3'd2;
    localparam logic [2:0] PH_ZERO = 3'd3;
    localparam logic [2:0] PH_END  = 3'd4;

    // byte tag
    localparam logic [2:0] KIND_HEAD = 3'd0;
    localparam logic [2:0] KIND_BODY = 3'd1;
    localparam logic [2:0] KIND_PAD  = 3'd2;
    localparam logic [2:0] KIND_ZERO = 3'd3;
    localparam logic [2:0] KIND_END  = 3'd4;

    typedef struct packed {
        logic [7:0]        byte_out;
        logic [2:0]        kind;
        logic              entry_ready;
        logic [SIZE_W-1:0] entry_size;
        logic [7:0]        entry_type;
        logic              body_last;
        logic              archive_end;
        logic              stream_done;
        logic              status;
    } tsd_result_t;

endpackage

// File: rtl/tar_stream_deframer_top.sv
// Tar stream deframer: takes an archive one byte per item and returns one result
// item per byte, tagging it as header, body data, padding, zero-led block or
// after-end, with the octal size and type flag on each header's last byte.
// Throughput is one byte per clock; each byte passes from acceptance to result
// through the input register, then the result register, with the state update
// of the parser between them. Backpressure on the result side stalls both
// stages; a new byte is still taken while a result waits if the input register
// is empty. An item with is_last set returns all state to reset, so the next
// byte starts a fresh archive.
module tar_stream_deframer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic [2:0]  kind,
    output logic        entry_ready,
    output logic [35:0] entry_size,
    output logic [7:0]  entry_type,
    output logic        body_last,
    output logic        archive_end,
    output logic        stream_done,
    output logic        status
);

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_byte_reg;
    logic                 s1_last_reg;
    logic                 out_valid_reg, out_valid_next;
    tsd_pkg::tsd_result_t out_res_reg;
    tsd_pkg::tsd_result_t step_res;
    logic                 advance;
    logic                 step_en;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign step_en  = s1_valid_reg && advance;

    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    tsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (s1_byte_reg),
        .is_last   (s1_last_reg),
        .result    (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= is_last;
        end
        if (step_en)
            out_res_reg <= step_res;
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = out_res_reg.byte_out;
    assign kind        = out_res_reg.kind;
    assign entry_ready = out_res_reg.entry_ready;
    assign entry_size  = out_res_reg.entry_size;
    assign entry_type  = out_res_reg.entry_type;
    assign body_last   = out_res_reg.body_last;
    assign archive_end = out_res_reg.archive_end;
    assign stream_done = out_res_reg.stream_done;
    assign status      = out_res_reg.status;

    a_ready_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && entry_ready) |-> (kind == tsd_pkg::KIND_HEAD))
        else $error("entry reported on a non-header byte");

    a_blast_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && body_last) |-> (kind == tsd_pkg::KIND_BODY))
        else $error("body end flagged outside body");

    a_aend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && archive_end) |-> (kind == tsd_pkg::KIND_ZERO))
        else $error("archive end flagged outside a zero block");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status) |-> stream_done)
        else $error("truncation status without end of stream");

    // a held result keeps the parser frozen
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !step_en)
        else $error("parser stepped while result stalled");

endmodule

// File: rtl/tsd_parser.sv
module tsd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           data_byte,
    input  logic                 is_last,
    output tsd_pkg::tsd_result_t result
);

    logic [2:0]                 phase_reg, phase_next;
    logic [tsd_pkg::OFF_W-1:0]  off_reg, off_next;
    logic [tsd_pkg::SIZE_W-1:0] acc_reg, acc_next;
    logic                       digit_reg, digit_next;
    logic                       stop_reg, stop_next;
    logic [7:0]                 type_reg, type_next;
    logic [tsd_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic                       az_reg, az_next;

    logic                       head_start;
    logic [2:0]                 cur_phase;
    logic [tsd_pkg::SIZE_W-1:0] cur_acc;
    logic                       cur_digit;
    logic                       cur_stop;
    logic [7:0]                 cur_type;
    logic                       cur_az;
    logic [tsd_pkg::OFF_W-1:0]  off_inc;
    logic [tsd_pkg::SIZE_W-1:0] rem_dec;
    logic                       is_octal;
    logic                       is_blank;

    assign off_inc  = off_reg + 9'd1;
    assign rem_dec  = (rem_reg != '0) ? rem_reg - 36'd1 : rem_reg;
    assign is_octal = data_byte inside {[tsd_pkg::CHR_ZERO:tsd_pkg::CHR_SEVEN]};
    assign is_blank = data_byte inside {tsd_pkg::CHR_NUL, tsd_pkg::CHR_SPACE};

    always_comb
    begin
        head_start = (phase_reg inside {tsd_pkg::PH_HEAD, tsd_pkg::PH_ZERO})
                     && (off_reg == '0);
        cur_phase  = head_start ? ((data_byte == 8'd0) ? tsd_pkg::PH_ZERO : tsd_pkg::PH_HEAD)
                                : phase_reg;
        cur_acc    = head_start ? '0   : acc_reg;
        cur_digit  = head_start ? 1'b0 : digit_reg;
        cur_stop   = head_start ? 1'b0 : stop_reg;
        cur_type   = head_start ? 8'd0 : type_reg;
        cur_az     = head_start ? 1'b1 : az_reg;

        phase_next = cur_phase;
        off_next   = off_reg;
        acc_next   = cur_acc;
        digit_next = cur_digit;
        stop_next  = cur_stop;
        type_next  = cur_type;
        rem_next   = rem_reg;
        az_next    = cur_az;

        result             = '0;
        result.byte_out    = data_byte;
        result.kind        = tsd_pkg::KIND_END;

        case (cur_phase)
            tsd_pkg::PH_ZERO:
            begin
                result.kind = tsd_pkg::KIND_ZERO;
                off_next    = off_inc;
                if (data_byte != 8'd0)
                    az_next = 1'b0;
                if (off_reg == tsd_pkg::BLK_LAST)
                begin
                    if (az_next)
                    begin
                        result.archive_end = 1'b1;
                        phase_next         = tsd_pkg::PH_END;
                    end
                    else
                        phase_next = tsd_pkg::PH_HEAD;
                end
            end
            tsd_pkg::PH_HEAD:
            begin
                result.kind = tsd_pkg::KIND_HEAD;
                off_next    = off_inc;
                if ((off_reg inside {[tsd_pkg::SIZE_OFF:tsd_pkg::SIZE_END]}) && !cur_stop)
                begin
                    // leading blanks skipped, a blank after a digit ends the field
                    if (is_blank)
                        stop_next = cur_digit;
                    else if (!is_octal)
                        stop_next = 1'b1;
                    else
                    begin
                        acc_next   = {cur_acc[tsd_pkg::SIZE_W-4:0], data_byte[2:0]};
                        digit_next = 1'b1;
                    end
                end
                if (off_reg == tsd_pkg::TYPE_OFF)
                    type_next = data_byte;
                if (off_reg == tsd_pkg::BLK_LAST)
                begin
                    result.entry_ready = 1'b1;
                    result.entry_size  = cur_acc;
                    result.entry_type  = cur_type;
                    if (cur_acc != '0)
                    begin
                        rem_next   = cur_acc;
                        phase_next = tsd_pkg::PH_BODY;
                    end
                end
            end
            tsd_pkg::PH_BODY:
            begin
                result.kind = tsd_pkg::KIND_BODY;
                off_next    = off_inc;
                rem_next    = rem_dec;
                if (rem_dec == '0)
                begin
                    result.body_last = 1'b1;
                    phase_next = (off_inc == '0) ? tsd_pkg::PH_HEAD : tsd_pkg::PH_PAD;
                end
            end
            tsd_pkg::PH_PAD:
            begin
                result.kind = tsd_pkg::KIND_PAD;
                off_next    = off_inc;
                if (off_inc == '0)
                    phase_next = tsd_pkg::PH_HEAD;
            end
            default:
            begin
                result.kind = tsd_pkg::KIND_END;
            end
        endcase

        if (is_last)
        begin
            result.stream_done = 1'b1;
            result.status      = phase_next inside {tsd_pkg::PH_BODY, tsd_pkg::PH_PAD};
            phase_next = tsd_pkg::PH_HEAD;
            off_next   = '0;
            acc_next   = '0;
            digit_next = 1'b0;
            stop_next  = 1'b0;
            type_next  = 8'd0;
            rem_next   = '0;
            az_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tsd_pkg::PH_HEAD;
            off_reg   <= '0;
            acc_reg   <= '0;
            digit_reg <= 1'b0;
            stop_reg  <= 1'b0;
            type_reg  <= 8'd0;
            rem_reg   <= '0;
            az_reg    <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            acc_reg   <= acc_next;
            digit_reg <= digit_next;
            stop_reg  <= stop_next;
            type_reg  <= type_next;
            rem_reg   <= rem_next;
            az_reg    <= az_next;
        end
    end

    // body countdown only runs with a nonzero count
    a_body_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_BODY) |-> (rem_reg != '0))
        else $error("body phase with zero remaining count");

    // padding never starts on a block boundary
    a_pad_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_PAD) |-> (off_reg != '0))
        else $error("padding phase at block offset zero");

    // after the end block the offset stays at a boundary
    a_end_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tsd_pkg::PH_END) |-> (off_reg == '0))
        else $error("end phase with nonzero offset");

endmodule
